>>> rtl/core/pclip_pkg.sv
// shared types and constants for the polyline level clipper
package pclip_pkg;
	localparam int unsigned CoordWidth = 32;
	localparam int unsigned DivSteps = CoordWidth;

	typedef logic signed [CoordWidth-1:0] coord_t;

	typedef enum logic [1:0] {
		KIND_VERTEX = 2'd0,
		KIND_CROSS  = 2'd1,
		KIND_GAP    = 2'd2,
		KIND_END    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT,
		ST_WAIT
	} state_t;

	// datapath status toward the controller
	typedef struct packed {
		logic crossing;
		logic below;
		logic div_done;
	} dp_status_t;

	// controller commands toward the datapath
	typedef struct packed {
		logic latch_in;
		logic div_start;
	} dp_cmd_t;
endpackage

>>> rtl/core/pclip_if.sv
// valid/ready channel interfaces for vertices and results
interface pclip_in_if;
	import pclip_pkg::*;
	logic valid;
	logic ready;
	coord_t vertex_y;
	coord_t vertex_z;
	logic is_final;
	modport source (output valid, vertex_y, vertex_z, is_final, input ready);
	modport sink (input valid, vertex_y, vertex_z, is_final, output ready);
endinterface

interface pclip_out_if;
	import pclip_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] item_kind;
	coord_t out_y;
	coord_t out_z;
	logic run_last;
	logic array_end;
	modport source (output valid, item_kind, out_y, out_z, run_last, array_end,
		input ready);
	modport sink (input valid, item_kind, out_y, out_z, run_last, array_end,
		output ready);
endinterface

>>> rtl/core/pclip_datapath.sv
// vertex registers, crossing test and serial restoring divider
module pclip_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pclip_pkg::dp_cmd_t       cmd,
	input  pclip_pkg::coord_t        clip_level,
	input  pclip_pkg::coord_t        in_y,
	input  pclip_pkg::coord_t        in_z,
	input  logic                     have_prev,
	output pclip_pkg::dp_status_t    status,
	output pclip_pkg::coord_t        cur_y,
	output pclip_pkg::coord_t        cur_z,
	output pclip_pkg::coord_t        cross_z
);
	import pclip_pkg::*;

	localparam int unsigned W = CoordWidth;

	coord_t prev_y_q, prev_z_q, cur_y_q, cur_z_q;
	logic [W-1:0] prod_q;
	logic [W-1:0] dvsr_q, quo_q, rem_q;
	logic [$clog2(DivSteps+1)-1:0] cnt_q;
	logic busy_q, done_q, zup_q;

	logic [W-1:0] a_abs, d_abs, dz_abs;
	logic [2*W-1:0] mul;
	logic [W:0] rem_sh;
	logic [W:0] rem_sub;
	logic zup;

	// signed compares of the stored vertex against the level
	assign status.below = (cur_y_q <= clip_level);
	assign status.crossing = have_prev &&
		(((prev_y_q < clip_level) && (clip_level < cur_y_q)) ||
		 ((clip_level < prev_y_q) && (cur_y_q < clip_level)));
	assign status.div_done = done_q;

	// operand magnitudes
	assign a_abs = (clip_level > prev_y_q) ? W'(clip_level - prev_y_q) :
		W'(prev_y_q - clip_level);
	assign d_abs = (cur_y_q > prev_y_q) ? W'(cur_y_q - prev_y_q) :
		W'(prev_y_q - cur_y_q);
	assign zup = (cur_z_q >= prev_z_q);
	assign dz_abs = zup ? W'(cur_z_q - prev_z_q) : W'(prev_z_q - cur_z_q);
	assign mul = (2*W)'(a_abs) * (2*W)'(dz_abs);

	// one restoring step per cycle
	assign rem_sh = {rem_q, prod_q[W-1]};
	assign rem_sub = rem_sh - {1'b0, dvsr_q};

	assign cross_z = zup_q ? coord_t'(prev_z_q + quo_q) : coord_t'(prev_z_q - quo_q);
	assign cur_y = cur_y_q;
	assign cur_z = cur_z_q;

	// vertex registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_y_q <= '0;
			prev_z_q <= '0;
			cur_y_q <= '0;
			cur_z_q <= '0;
		end else if (cmd.latch_in) begin
			prev_y_q <= cur_y_q;
			prev_z_q <= cur_z_q;
			cur_y_q <= in_y;
			cur_z_q <= in_z;
		end
	end

	// divider control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.div_start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($bits(cnt_q))'(DivSteps-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// divider datapath; a < d keeps the upper product half below the divisor,
	// so it seeds the remainder and only the lower half is shifted in
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			prod_q <= mul[W-1:0];
			dvsr_q <= d_abs;
			rem_q <= mul[2*W-1:W];
			quo_q <= '0;
			zup_q <= zup;
		end else if (busy_q) begin
			prod_q <= {prod_q[W-2:0], 1'b0};
			if (!rem_sub[W]) begin
				rem_q <= rem_sub[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end
endmodule

>>> rtl/core/pclip_ctrl.sv
// controller: sequences crossing, gap, vertex and end results
module pclip_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	pclip_in_if.sink              vin,
	pclip_out_if.source           vout,
	input  pclip_pkg::dp_status_t status,
	input  pclip_pkg::coord_t     clip_level,
	input  pclip_pkg::coord_t     cur_y,
	input  pclip_pkg::coord_t     cur_z,
	input  pclip_pkg::coord_t     cross_z,
	output pclip_pkg::dp_cmd_t    cmd,
	output logic                  have_prev
);
	import pclip_pkg::*;

	state_t state_q, state_d;
	logic have_prev_q, lwp_q, gap_q, fin_q;
	logic cross_q, vert_q, end_q;
	logic [1:0] kind_q;
	coord_t oy_q, oz_q;
	logic last_q, aend_q, ovalid_q;

	// next item selection from the pending flags
	logic emit_gap, emit_cross, emit_vert, emit_end, more;
	logic [1:0] e_kind;
	coord_t e_y, e_z;
	logic load_out;

	assign have_prev = have_prev_q;
	assign vin.ready = (state_q == ST_IDLE);
	assign vout.valid = ovalid_q;
	assign vout.item_kind = kind_q;
	assign vout.out_y = oy_q;
	assign vout.out_z = oz_q;
	assign vout.run_last = last_q;
	assign vout.array_end = aend_q;

	// output register takes a new result
	assign load_out = (state_q == ST_EMIT) && (!ovalid_q || vout.ready) &&
		(cross_q || vert_q || end_q);

	always_comb begin
		emit_gap = gap_q && (cross_q || vert_q);
		emit_cross = !emit_gap && cross_q;
		emit_vert = !emit_gap && !cross_q && vert_q;
		emit_end = !emit_gap && !cross_q && !vert_q && end_q;
		e_kind = KIND_GAP;
		e_y = '0;
		e_z = '0;
		if (emit_cross) begin
			e_kind = KIND_CROSS;
			e_y = clip_level;
			e_z = cross_z;
		end else if (emit_vert) begin
			e_kind = KIND_VERTEX;
			e_y = cur_y;
			e_z = cur_z;
		end else if (emit_end) begin
			e_kind = KIND_END;
		end
		more = emit_gap || (emit_cross && vert_q);
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (vin.valid) begin
					cmd.latch_in = 1'b1;
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (status.crossing) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DIV: begin
				if (status.div_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!ovalid_q || vout.ready) begin
					if (!(cross_q || vert_q || end_q)) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// flags and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			lwp_q <= 1'b0;
			gap_q <= 1'b0;
			fin_q <= 1'b0;
			cross_q <= 1'b0;
			vert_q <= 1'b0;
			end_q <= 1'b0;
			ovalid_q <= 1'b0;
			kind_q <= '0;
			oy_q <= '0;
			oz_q <= '0;
			last_q <= 1'b0;
			aend_q <= 1'b0;
		end else begin
			if (load_out) ovalid_q <= 1'b1;
			else if (vout.ready) ovalid_q <= 1'b0;
			if (state_q == ST_IDLE && vin.valid) fin_q <= vin.is_final;
			if (state_q == ST_WAIT) begin
				cross_q <= status.crossing;
				vert_q <= status.below;
				end_q <= fin_q && !status.crossing && !status.below;
			end
			if (state_q == ST_EMIT && (!ovalid_q || vout.ready)) begin
				if (cross_q || vert_q || end_q) begin
					kind_q <= e_kind;
					oy_q <= e_y;
					oz_q <= e_z;
					last_q <= !more;
					aend_q <= !more && fin_q;
					if (emit_gap) gap_q <= 1'b0;
					if (emit_cross) begin
						cross_q <= 1'b0;
						lwp_q <= 1'b1;
					end
					if (emit_vert) begin
						vert_q <= 1'b0;
						lwp_q <= 1'b1;
					end
					if (emit_end) end_q <= 1'b0;
				end else begin
					// step done: update run state
					if (fin_q) begin
						have_prev_q <= 1'b0;
						lwp_q <= 1'b0;
						gap_q <= 1'b0;
					end else begin
						have_prev_q <= 1'b1;
						if (have_prev_q && lwp_q && !(cur_y <= clip_level)) begin
							gap_q <= 1'b1;
							lwp_q <= 1'b0;
						end
					end
				end
			end
		end
	end
endmodule

>>> rtl/core/polyline_clip_below_level_core.sv
// top level of the polyline clipper at a horizontal level
//  channel | dir | payload
//  vin     | in  | vertex_y, vertex_z, is_final
//  vout    | out | item_kind, out_y, out_z, run_last, array_end
//  cfg     | in  | cfg_we, cfg_wdata -> clip_level
// one vertex at a time: IDLE, WAIT, then EMIT until the results are out, with
// ST_DIV for the serial restoring divider after WAIT when a segment crosses
// the level (at most a crossing, a gap and a vertex per vertex).
// arst_n clears control state and clip_level; stalls on vout hold results.
module polyline_clip_below_level_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  pclip_pkg::coord_t cfg_wdata,
	pclip_in_if.sink          vin,
	pclip_out_if.source       vout
);
	import pclip_pkg::*;

	coord_t level_q, cur_y, cur_z, cross_z;
	dp_cmd_t cmd;
	dp_status_t status;
	logic have_prev;

	// level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) level_q <= '0;
		else if (cfg_we) level_q <= cfg_wdata;
	end

	pclip_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .vin(vin), .vout(vout), .status(status),
		.clip_level(level_q), .cur_y(cur_y), .cur_z(cur_z), .cross_z(cross_z),
		.cmd(cmd), .have_prev(have_prev)
	);

	pclip_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .clip_level(level_q),
		.in_y(vin.vertex_y), .in_z(vin.vertex_z), .have_prev(have_prev),
		.status(status), .cur_y(cur_y), .cur_z(cur_z), .cross_z(cross_z)
	);
endmodule

>>> dv/tb_polyline_clip_below_level_core.sv
`timescale 1ns / 1ps
// testbench for the polyline level clipper: random and directed vertices, scoreboarded results
module tb_polyline_clip_below_level_core;
	import pclip_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		coord_t y;
		coord_t z;
		logic   fin;
	} vertex_t;

	typedef struct packed {
		kind_t  kind;
		coord_t y;
		coord_t z;
		logic   run_last;
		logic   array_end;
	} clip_item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	coord_t cfg_wdata;

	pclip_in_if vin();
	pclip_out_if vout();

	polyline_clip_below_level_core u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.vin(vin.sink), .vout(vout.source)
	);

	// predictor state
	coord_t level_q;
	coord_t prev_y_q, prev_z_q;
	logic have_prev_q, last_point_q, gap_pend_q;

	vertex_t pending_vertices[$];
	clip_item_t expected_items[$];
	int src_idle_pct, snk_idle_pct;
	int mismatch_count;
	int stall_count;
	bit stim_done;
	bit in_taken_q;

	// emit one point, preceded by a pending gap
	function automatic void push_point(ref clip_item_t run[$], input kind_t k,
			input coord_t y, input coord_t z);
		clip_item_t it;
		if (gap_pend_q) begin
			it = '{KIND_GAP, '0, '0, 1'b0, 1'b0};
			run.push_back(it);
		end
		gap_pend_q = 1'b0;
		it = '{k, y, z, 1'b0, 1'b0};
		run.push_back(it);
		last_point_q = 1'b1;
	endfunction

	// clipped results of one vertex
	function automatic void clip_vertex(vertex_t v);
		clip_item_t run[$];
		logic [63:0] a, d, dz, off;
		logic [127:0] prod;
		coord_t zi;
		logic up;
		logic below;
		below = v.y <= level_q;
		if (have_prev_q) begin
			if ((prev_y_q < level_q && level_q < v.y) ||
					(level_q < prev_y_q && v.y < level_q)) begin
				a = (level_q > prev_y_q) ? 64'(level_q) - 64'(prev_y_q)
					: 64'(prev_y_q) - 64'(level_q);
				d = (v.y > prev_y_q) ? 64'(v.y) - 64'(prev_y_q)
					: 64'(prev_y_q) - 64'(v.y);
				up = v.z >= prev_z_q;
				dz = up ? 64'(v.z) - 64'(prev_z_q) : 64'(prev_z_q) - 64'(v.z);
				prod = 128'(a) * 128'(dz);
				off = 64'(prod / 128'(d));
				zi = up ? prev_z_q + coord_t'(off) : prev_z_q - coord_t'(off);
				push_point(run, KIND_CROSS, level_q, zi);
			end
			if (below) push_point(run, KIND_VERTEX, v.y, v.z);
			if (last_point_q && !below && !v.fin) begin
				gap_pend_q = 1'b1;
				last_point_q = 1'b0;
			end
		end else if (below) begin
			push_point(run, KIND_VERTEX, v.y, v.z);
		end
		prev_y_q = v.y;
		prev_z_q = v.z;
		have_prev_q = 1'b1;
		if (v.fin) begin
			if (run.size() == 0) run.push_back('{KIND_END, '0, '0, 1'b0, 1'b0});
			run[run.size()-1].array_end = 1'b1;
			have_prev_q = 1'b0;
			last_point_q = 1'b0;
			gap_pend_q = 1'b0;
			prev_y_q = '0;
			prev_z_q = '0;
		end
		if (run.size() > 0) run[run.size()-1].run_last = 1'b1;
		foreach (run[i]) expected_items.push_back(run[i]);
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 5))
			0: return coord_t'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
			1: return coord_t'($urandom_range(0, 64)) - 32;
			2: return coord_t'($urandom_range(0, 8000)) - 4000;
			default: return coord_t'($urandom);
		endcase
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// vertex driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vin.valid <= 1'b0;
			vin.vertex_y <= '0;
			vin.vertex_z <= '0;
			vin.is_final <= 1'b0;
		end else begin
			if (!vin.valid || in_taken_q) begin
				if (pending_vertices.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					vin.valid <= 1'b1;
					{vin.vertex_y, vin.vertex_z, vin.is_final} <= pending_vertices[0];
				end else begin
					vin.valid <= 1'b0;
				end
			end
		end
	end

	// sink ready
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) vout.ready <= 1'b0;
		else vout.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	// input transfer: predict; output transfer: compare
	always @(posedge clk) begin
		clip_item_t exp_it;
		in_taken_q <= vin.valid && vin.ready;
		if (arst_n) begin
			if ((vin.valid && vin.ready) || (vout.valid && vout.ready))
				stall_count <= 0;
			else
				stall_count <= stall_count + 1;
			if (vin.valid && vin.ready) begin
				clip_vertex(pending_vertices.pop_front());
			end
			if (vout.valid && vout.ready) begin
				if (expected_items.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result kind=%0d y=%0d z=%0d",
							vout.item_kind, vout.out_y, vout.out_z);
				end else begin
					exp_it = expected_items.pop_front();
					if (vout.item_kind !== exp_it.kind || vout.out_y !== exp_it.y ||
							vout.out_z !== exp_it.z || vout.run_last !== exp_it.run_last ||
							vout.array_end !== exp_it.array_end) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch exp k=%0d y=%0d z=%0d rl=%0b ae=%0b",
								exp_it.kind, exp_it.y, exp_it.z, exp_it.run_last,
								exp_it.array_end,
								" got k=%0d y=%0d z=%0d rl=%0b ae=%0b",
								vout.item_kind, vout.out_y, vout.out_z, vout.run_last,
								vout.array_end);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (stall_count >= WATCHDOG_LIMIT) begin
			$display("polyline_clip_below_level_core regression: fail");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_vertices.size() > 0 || expected_items.size() > 0 || vin.valid)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_level(coord_t lv);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= lv;
		@(negedge clk);
		cfg_we <= 1'b0;
		level_q = lv;
	endtask

	// random polyline mostly straddling the level
	task automatic queue_polyline(int n);
		vertex_t v;
		for (int i = 0; i < n; i++) begin
			v.y = ($urandom_range(0, 3) == 0) ? rand_coord()
				: level_q + coord_t'($urandom_range(0, 2000)) - 1000;
			if ($urandom_range(0, 9) == 0) v.y = level_q;
			v.z = rand_coord();
			v.fin = (i == n - 1);
			pending_vertices.push_back(v);
		end
	endtask

	initial begin
		coord_t levels[6];
		int sent;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		src_idle_pct = 21;
		snk_idle_pct = 74;
		mismatch_count = 0;
		stall_count = 0;
		level_q = '0;
		prev_y_q = '0;
		prev_z_q = '0;
		have_prev_q = 1'b0;
		last_point_q = 1'b0;
		gap_pend_q = 1'b0;
		repeat (3) @(posedge clk);
		arst_n = 1'b1;

		// directed: level 0, extremes, touching, gaps, empty result
		pending_vertices.push_back('{32'sh80000000, 32'sh7fffffff, 1'b0});
		pending_vertices.push_back('{32'sh7fffffff, 32'sh80000000, 1'b0});
		pending_vertices.push_back('{-32'sd5, 32'sd100, 1'b0});
		pending_vertices.push_back('{32'sd0, 32'sd50, 1'b0});
		pending_vertices.push_back('{32'sd10, 32'sd60, 1'b0});
		pending_vertices.push_back('{32'sd20, 32'sd70, 1'b0});
		pending_vertices.push_back('{-32'sd3, -32'sd7, 1'b0});
		pending_vertices.push_back('{32'sd9, 32'sd1, 1'b1});
		pending_vertices.push_back('{32'sd5, 32'sd1, 1'b0});
		pending_vertices.push_back('{32'sd6, 32'sd2, 1'b1});
		pending_vertices.push_back('{-32'sd1, 32'sd0, 1'b1});
		pending_vertices.push_back('{32'sd4, 32'sd0, 1'b0});
		pending_vertices.push_back('{-32'sd4, 32'sd8, 1'b1});
		wait_drained();

		levels = '{32'sh7fffffff, 32'sh80000000, 32'sd65536, -32'sd65536, 32'sd0, 32'sd1234};
		sent = 13;
		for (int ph = 0; ph < 6; ph++) begin
			write_level(levels[ph]);
			if (ph == 2) begin
				src_idle_pct = 74;
				snk_idle_pct = 21;
			end
			if (ph == 4) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			while (sent < 13 + (ph + 1) * 73) begin
				int n;
				n = $urandom_range(1, 12);
				queue_polyline(n);
				sent += n;
			end
			wait_drained();
		end

		if (mismatch_count == 0 && expected_items.size() == 0)
			$display("polyline_clip_below_level_core regression: pass");
		else
			$display("polyline_clip_below_level_core regression: fail");
		$finish;
	end
endmodule

>>> files.f
rtl/core/pclip_pkg.sv
rtl/core/pclip_if.sv
rtl/core/pclip_datapath.sv
rtl/core/pclip_ctrl.sv
rtl/core/polyline_clip_below_level_core.sv
dv/tb_polyline_clip_below_level_core.sv
